// ===== rtl/core/lole_pkg.sv =====
// lole_pkg: shared types, codes and the microcode ROM for the linked order list engine.
// No dependencies; used by lole_seq, lole_dpath and the top level.
package lole_pkg;

	localparam int LOLE_MAX_ITEMS = 1024;
	localparam int OP_W = 3;
	localparam int ITEM_W = 11;
	localparam int CFG_W = 11;
	localparam int SUM_W = 20;
	localparam int ITEM_COUNT_RST = 1024;
	localparam int UPC_W = 6;

	localparam logic [OP_W-1:0] OP_INIT = 3'd0;
	localparam logic [OP_W-1:0] OP_LEFT = 3'd1;
	localparam logic [OP_W-1:0] OP_RIGHT = 3'd2;
	localparam logic [OP_W-1:0] OP_SWAP = 3'd3;
	localparam logic [OP_W-1:0] OP_REV = 3'd4;
	localparam logic [OP_W-1:0] OP_REPORT = 3'd5;

	typedef logic [UPC_W-1:0] upc_t;

	// operand sources for link table addresses and write data
	typedef enum logic [3:0] {
		OPD_ZERO,
		OPD_X,
		OPD_Y,
		OPD_PX,
		OPD_NX,
		OPD_PY,
		OPD_NY,
		OPD_IDX,
		OPD_IDX_NEXT,
		OPD_IDX_PREV,
		OPD_WALK
	} opnd_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_PD_EQ_X,
		COND_ND_EQ_X,
		COND_ND_EQ_Y,
		COND_IDX_NE_CNT,
		COND_WALK_GO,
		COND_OUT_BUSY
	} cond_t;

	typedef enum logic [2:0] {
		MISC_NONE,
		MISC_INIT_START,
		MISC_INIT_STEP,
		MISC_WALK_START,
		MISC_WALK_STEP,
		MISC_EMIT,
		MISC_TOGGLE
	} misc_t;

	typedef struct packed {
		opnd_t rd_p_sel;
		opnd_t rd_n_sel;
		logic  ld_px;
		logic  ld_nx;
		logic  ld_py;
		logic  ld_ny;
		logic  wr_p;
		opnd_t wr_p_addr;
		opnd_t wr_p_data;
		logic  wr_n;
		opnd_t wr_n_addr;
		opnd_t wr_n_data;
		cond_t cond;
		upc_t  target;
		logic  last;
		misc_t misc;
	} ctrl_word_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic args_ok;
		logic rev;
		logic pd_eq_x;
		logic nd_eq_x;
		logic nd_eq_y;
		logic idx_ne_cnt;
		logic walk_go;
		logic out_busy;
	} stat_t;

	// microprogram entry points
	localparam upc_t U_ML0 = 6'd0;    // move x before y, 8 steps
	localparam upc_t U_MR0 = 6'd8;    // move x after y, 8 steps
	localparam upc_t U_SW0 = 6'd16;   // swap, general, 7 steps
	localparam upc_t U_SA0 = 6'd23;   // swap, x directly before y
	localparam upc_t U_SB0 = 6'd27;   // swap, y directly before x
	localparam upc_t U_INIT0 = 6'd30;
	localparam upc_t U_INIT1 = 6'd31;
	localparam upc_t U_REP0 = 6'd32;
	localparam upc_t U_REP1 = 6'd33;
	localparam upc_t U_REP2 = 6'd34;
	localparam upc_t U_REV = 6'd35;
	localparam upc_t U_DONE = 6'd36;

	localparam ctrl_word_t CW_NOP = '{
		rd_p_sel: OPD_ZERO, rd_n_sel: OPD_ZERO,
		ld_px: 1'b0, ld_nx: 1'b0, ld_py: 1'b0, ld_ny: 1'b0,
		wr_p: 1'b0, wr_p_addr: OPD_ZERO, wr_p_data: OPD_ZERO,
		wr_n: 1'b0, wr_n_addr: OPD_ZERO, wr_n_data: OPD_ZERO,
		cond: COND_NEVER, target: U_DONE, last: 1'b0, misc: MISC_NONE
	};

	function automatic ctrl_word_t wp(input ctrl_word_t w, input opnd_t a, input opnd_t d);
		ctrl_word_t r;
		r = w;
		r.wr_p = 1'b1;
		r.wr_p_addr = a;
		r.wr_p_data = d;
		return r;
	endfunction

	function automatic ctrl_word_t wn(input ctrl_word_t w, input opnd_t a, input opnd_t d);
		ctrl_word_t r;
		r = w;
		r.wr_n = 1'b1;
		r.wr_n_addr = a;
		r.wr_n_data = d;
		return r;
	endfunction

	function automatic ctrl_word_t jmp(input ctrl_word_t w, input cond_t c, input upc_t t);
		ctrl_word_t r;
		r = w;
		r.cond = c;
		r.target = t;
		return r;
	endfunction

	// microcode ROM; reads issued in one step return data in the next
	function automatic ctrl_word_t rom_word(input upc_t a);
		ctrl_word_t w;
		w = CW_NOP;
		unique case (a)
			// move x before y
			6'd0: begin w.rd_p_sel = OPD_Y; w.rd_n_sel = OPD_X; end
			6'd1: begin
				w = jmp(w, COND_PD_EQ_X, U_DONE);
				w.ld_nx = 1'b1;
				w.rd_p_sel = OPD_X;
			end
			6'd2: w.ld_px = 1'b1;
			6'd3: w = wp(wn(w, OPD_PX, OPD_NX), OPD_NX, OPD_PX);
			6'd4: w.rd_p_sel = OPD_Y;   // re-read after unlink
			6'd5: w.ld_py = 1'b1;
			6'd6: w = wp(wn(w, OPD_PY, OPD_X), OPD_X, OPD_PY);
			6'd7: begin w = wp(wn(w, OPD_X, OPD_Y), OPD_Y, OPD_X); w.last = 1'b1; end
			// move x after y
			6'd8: begin w.rd_p_sel = OPD_X; w.rd_n_sel = OPD_Y; end
			6'd9: begin
				w = jmp(w, COND_ND_EQ_X, U_DONE);
				w.ld_px = 1'b1;
				w.rd_n_sel = OPD_X;
			end
			6'd10: w.ld_nx = 1'b1;
			6'd11: w = wp(wn(w, OPD_PX, OPD_NX), OPD_NX, OPD_PX);
			6'd12: w.rd_n_sel = OPD_Y;
			6'd13: w.ld_ny = 1'b1;
			6'd14: w = wp(wn(w, OPD_X, OPD_NY), OPD_NY, OPD_X);
			6'd15: begin w = wp(wn(w, OPD_Y, OPD_X), OPD_X, OPD_Y); w.last = 1'b1; end
			// swap
			6'd16: begin w.rd_p_sel = OPD_X; w.rd_n_sel = OPD_X; end
			6'd17: begin
				w = jmp(w, COND_ND_EQ_Y, U_SA0);
				w.ld_px = 1'b1;
				w.ld_nx = 1'b1;
				w.rd_p_sel = OPD_Y;
				w.rd_n_sel = OPD_Y;
			end
			6'd18: begin
				w = jmp(w, COND_ND_EQ_X, U_SB0);
				w.ld_py = 1'b1;
				w.ld_ny = 1'b1;
			end
			6'd19: w = wp(wn(w, OPD_PX, OPD_Y), OPD_NX, OPD_Y);
			6'd20: w = wp(wn(w, OPD_PY, OPD_X), OPD_NY, OPD_X);
			6'd21: w = wp(wn(w, OPD_Y, OPD_NX), OPD_Y, OPD_PX);
			6'd22: begin w = wp(wn(w, OPD_X, OPD_NY), OPD_X, OPD_PY); w.last = 1'b1; end
			// swap, x then y adjacent
			6'd23: begin w.ld_py = 1'b1; w.ld_ny = 1'b1; end
			6'd24: w = wp(wn(w, OPD_PX, OPD_Y), OPD_Y, OPD_PX);
			6'd25: w = wp(wn(w, OPD_X, OPD_NY), OPD_NY, OPD_X);
			6'd26: begin w = wp(wn(w, OPD_Y, OPD_X), OPD_X, OPD_Y); w.last = 1'b1; end
			// swap, y then x adjacent
			6'd27: w = wp(wn(w, OPD_PY, OPD_X), OPD_X, OPD_PY);
			6'd28: w = wp(wn(w, OPD_Y, OPD_NX), OPD_NX, OPD_Y);
			6'd29: begin w = wp(wn(w, OPD_X, OPD_Y), OPD_Y, OPD_X); w.last = 1'b1; end
			// init: one node per step
			6'd30: w.misc = MISC_INIT_START;
			6'd31: begin
				w = wp(wn(w, OPD_IDX, OPD_IDX_NEXT), OPD_IDX, OPD_IDX_PREV);
				w = jmp(w, COND_IDX_NE_CNT, U_INIT1);
				w.misc = MISC_INIT_STEP;
				w.last = 1'b1;
			end
			// report: one node per step, address taken straight from read data
			6'd32: begin
				w.rd_p_sel = OPD_ZERO;
				w.rd_n_sel = OPD_ZERO;
				w.misc = MISC_WALK_START;
			end
			6'd33: begin
				w.rd_p_sel = OPD_WALK;
				w.rd_n_sel = OPD_WALK;
				w = jmp(w, COND_WALK_GO, U_REP1);
				w.misc = MISC_WALK_STEP;
			end
			6'd34: begin
				w = jmp(w, COND_OUT_BUSY, U_REP2);
				w.misc = MISC_EMIT;
				w.last = 1'b1;
			end
			6'd35: begin w.misc = MISC_TOGGLE; w.last = 1'b1; end
			default: w.last = 1'b1;
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/linked_order_list_engine.sv =====
// linked_order_list_engine: top level; microcoded sequencer plus link table datapath.
// Depends on lole_pkg, lole_seq, lole_dpath (which holds lole_link_ram).
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------
//   in       | in_valid / in_ready   | op, item_x, item_y
//   out      | out_valid / out_ready | odd_position_sum
//   cfg      | cfg_wr_en             | cfg_wr_data (item_count)
//
// A move that finds x already in place ends early, an adjacent swap takes a
// shorter path than a general one, and dropped items never make the engine busy.
// Each link table has one write port and one registered read port, so every
// dependent link read costs a step of the microprogram.
// Reset leaves the link tables unwritten; item_count returns to 1024.
// A report waits in its last step while the previous result is still held.
module linked_order_list_engine import lole_pkg::*; #(
	parameter int MAX_ITEMS = LOLE_MAX_ITEMS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   op,
	input  logic [ITEM_W-1:0] item_x,
	input  logic [ITEM_W-1:0] item_y,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SUM_W-1:0]  odd_position_sum,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data
);

	ctrl_word_t ctrl;
	stat_t      stat;
	logic       in_fire;

	assign in_fire = in_valid && in_ready;

	lole_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.op       (op),
		.stat     (stat),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	lole_dpath #(.MAX_ITEMS(MAX_ITEMS)) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_fire          (in_fire),
		.item_x           (item_x),
		.item_y           (item_y),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.ctrl             (ctrl),
		.out_ready        (out_ready),
		.stat             (stat),
		.out_valid        (out_valid),
		.odd_position_sum (odd_position_sum)
	);

	// a report always makes the sequencer busy once it is taken
	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (op == OP_REPORT)) |=> !in_ready)
		else $error("report accepted without going busy");

	// results only come out of a running microprogram
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result raised while sequencer idle");

	// init always makes the sequencer busy once it is taken
	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (op == OP_INIT)) |=> !in_ready)
		else $error("init accepted without going busy");

endmodule

// ===== rtl/core/lole_link_ram.sv =====
// lole_link_ram: one link table, single write port and one registered read port.
// Depends on nothing; instanced twice by lole_dpath.
module lole_link_ram #(
	parameter int DEPTH = 1025,
	parameter int W = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/lole_seq.sv =====
// lole_seq: microprogram counter, ROM lookup, op dispatch and conditional jumps.
// Depends on lole_pkg (ROM, control word and status types).
module lole_seq import lole_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic [OP_W-1:0] op,
	input  stat_t           stat,
	output logic            in_ready,
	output ctrl_word_t      ctrl
);

	logic       busy_q, busy_d;
	upc_t       upc_q, upc_d;
	ctrl_word_t cw;
	logic       cond_true;
	logic       start;
	upc_t       entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q <= U_DONE;
		end else begin
			busy_q <= busy_d;
			upc_q <= upc_d;
		end
	end

	assign cw = rom_word(upc_q);
	assign ctrl = busy_q ? cw : CW_NOP;
	assign in_ready = !busy_q;

	always_comb begin
		unique case (cw.cond)
			COND_PD_EQ_X:    cond_true = stat.pd_eq_x;
			COND_ND_EQ_X:    cond_true = stat.nd_eq_x;
			COND_ND_EQ_Y:    cond_true = stat.nd_eq_y;
			COND_IDX_NE_CNT: cond_true = stat.idx_ne_cnt;
			COND_WALK_GO:    cond_true = stat.walk_go;
			COND_OUT_BUSY:   cond_true = stat.out_busy;
			default:         cond_true = 1'b0;
		endcase
	end

	// bad arguments and unused ops are taken and dropped here
	always_comb begin
		start = 1'b0;
		entry = U_DONE;
		unique case (op)
			OP_INIT: begin start = 1'b1; entry = U_INIT0; end
			OP_LEFT, OP_RIGHT: begin
				start = stat.args_ok;
				entry = ((op == OP_LEFT) ^ stat.rev) ? U_ML0 : U_MR0;
			end
			OP_SWAP: begin start = stat.args_ok; entry = U_SW0; end
			OP_REV: begin start = 1'b1; entry = U_REV; end
			OP_REPORT: begin start = 1'b1; entry = U_REP0; end
			default: begin start = 1'b0; entry = U_DONE; end
		endcase
	end

	always_comb begin
		busy_d = busy_q;
		upc_d = upc_q;
		if (!busy_q) begin
			if (in_fire && start) begin
				busy_d = 1'b1;
				upc_d = entry;
			end
		end else if (cond_true) begin
			upc_d = cw.target;
		end else if (cw.last) begin
			busy_d = 1'b0;
		end else begin
			upc_d = upc_q + 1'b1;
		end
	end

endmodule

// ===== rtl/core/lole_dpath.sv =====
// lole_dpath: operand registers, counters, link tables and the result register.
// Depends on lole_pkg and lole_link_ram; driven by the control word from lole_seq.
module lole_dpath import lole_pkg::*; #(
	parameter int MAX_ITEMS = LOLE_MAX_ITEMS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [ITEM_W-1:0] item_x,
	input  logic [ITEM_W-1:0] item_y,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  ctrl_word_t        ctrl,
	input  logic              out_ready,
	output stat_t             stat,
	output logic              out_valid,
	output logic [SUM_W-1:0]  odd_position_sum
);

	localparam int NW = $clog2(MAX_ITEMS + 1);
	localparam int CW = (NW > CFG_W) ? NW : CFG_W;

	logic [CFG_W-1:0] item_count_q;
	logic             rev_q;
	logic [NW-1:0]    x_q, y_q, px_q, nx_q, py_q, ny_q;
	logic [NW-1:0]    idx_q, steps_q;
	logic             odd_q;
	logic [SUM_W-1:0] sum_q, out_sum_q;
	logic             out_valid_q;

	logic [CW-1:0]    ic_w, cnt_w;
	logic [NW-1:0]    cnt;
	logic             args_ok;
	logic [NW-1:0]    pdata, ndata, pd_n, nd_n, walk_node;
	logic [NW-1:0]    p_raddr, n_raddr, p_waddr, p_wdata, n_waddr, n_wdata;
	logic             walk_go, out_busy, emit;

	// item_count of 0 acts as 1, above MAX_ITEMS as MAX_ITEMS
	assign ic_w = CW'(item_count_q);
	assign cnt = (ic_w == '0) ? NW'(1)
		: (ic_w > CW'(MAX_ITEMS)) ? NW'(MAX_ITEMS) : NW'(ic_w);
	assign cnt_w = CW'(cnt);
	assign args_ok = (item_x != '0) && (item_y != '0) && (item_x != item_y)
		&& (CW'(item_x) <= cnt_w) && (CW'(item_y) <= cnt_w);

	// out-of-range links read as the sentinel
	assign pd_n = (pdata > NW'(MAX_ITEMS)) ? '0 : pdata;
	assign nd_n = (ndata > NW'(MAX_ITEMS)) ? '0 : ndata;
	assign walk_node = rev_q ? pd_n : nd_n;
	assign walk_go = (walk_node != '0) && (steps_q != NW'(MAX_ITEMS));
	assign out_busy = out_valid_q && !out_ready;
	assign emit = (ctrl.misc == MISC_EMIT) && !out_busy;

	function automatic logic [NW-1:0] pick(input opnd_t s);
		logic [NW-1:0] v;
		case (s)
			OPD_X:        v = x_q;
			OPD_Y:        v = y_q;
			OPD_PX:       v = px_q;
			OPD_NX:       v = nx_q;
			OPD_PY:       v = py_q;
			OPD_NY:       v = ny_q;
			OPD_IDX:      v = idx_q;
			OPD_IDX_NEXT: v = (idx_q == cnt) ? '0 : idx_q + NW'(1);
			OPD_IDX_PREV: v = (idx_q == '0) ? cnt : idx_q - NW'(1);
			OPD_WALK:     v = walk_node;
			default:      v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		p_raddr = pick(ctrl.rd_p_sel);
		n_raddr = pick(ctrl.rd_n_sel);
		p_waddr = pick(ctrl.wr_p_addr);
		p_wdata = pick(ctrl.wr_p_data);
		n_waddr = pick(ctrl.wr_n_addr);
		n_wdata = pick(ctrl.wr_n_data);
	end

	lole_link_ram #(.DEPTH(MAX_ITEMS + 1), .W(NW)) u_prev (
		.clk   (clk),
		.we    (ctrl.wr_p),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (pdata)
	);

	lole_link_ram #(.DEPTH(MAX_ITEMS + 1), .W(NW)) u_next (
		.clk   (clk),
		.we    (ctrl.wr_n),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (n_raddr),
		.rdata (ndata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= CFG_W'(ITEM_COUNT_RST);
			rev_q <= 1'b0;
			idx_q <= '0;
			steps_q <= '0;
			odd_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				item_count_q <= cfg_wr_data;
			end
			unique case (ctrl.misc)
				MISC_INIT_START: begin
					idx_q <= '0;
					rev_q <= 1'b0;
				end
				MISC_INIT_STEP: idx_q <= idx_q + NW'(1);
				MISC_WALK_START: begin
					steps_q <= '0;
					odd_q <= 1'b1;
				end
				MISC_WALK_STEP: begin
					if (walk_go) begin
						steps_q <= steps_q + NW'(1);
						odd_q <= ~odd_q;
					end
				end
				MISC_TOGGLE: rev_q <= ~rev_q;
				default: ;
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= NW'(item_x);
			y_q <= NW'(item_y);
		end
		if (ctrl.ld_px) px_q <= pd_n;
		if (ctrl.ld_nx) nx_q <= nd_n;
		if (ctrl.ld_py) py_q <= pd_n;
		if (ctrl.ld_ny) ny_q <= nd_n;
		if (ctrl.misc == MISC_WALK_START) begin
			sum_q <= '0;
		end else if ((ctrl.misc == MISC_WALK_STEP) && walk_go && odd_q) begin
			sum_q <= sum_q + SUM_W'(walk_node);   // wraps at 20 bits
		end
		if (emit) begin
			out_sum_q <= sum_q;
		end
	end

	assign stat = '{
		args_ok: args_ok,
		rev: rev_q,
		pd_eq_x: (pd_n == x_q),
		nd_eq_x: (nd_n == x_q),
		nd_eq_y: (nd_n == y_q),
		idx_ne_cnt: (idx_q != cnt),
		walk_go: walk_go,
		out_busy: out_busy
	};

	assign out_valid = out_valid_q;
	assign odd_position_sum = out_sum_q;

endmodule
